FILE: design/sue_pkg.sv
// shared types, character codes and helpers for the string unescaper
`timescale 1ns / 1ps

package sue_pkg;

  // decoder mode
  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_ESC    = 2'd1,
    MODE_HEX_X  = 2'd2,
    MODE_HEX_U  = 2'd3
  } mode_t;

  // result kind codes
  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_END  = 2'd1,
    KIND_ERR  = 2'd2
  } kind_t;

  // character codes
  localparam logic [7:0] CHAR_NUL    = 8'h00;
  localparam logic [7:0] CHAR_DQUOTE = 8'h22;
  localparam logic [7:0] CHAR_APOS   = 8'h27;
  localparam logic [7:0] CHAR_SLASH  = 8'h2F;
  localparam logic [7:0] CHAR_BSLASH = 8'h5C;
  localparam logic [7:0] CHAR_LC_B   = 8'h62;
  localparam logic [7:0] CHAR_LC_F   = 8'h66;
  localparam logic [7:0] CHAR_LC_N   = 8'h6E;
  localparam logic [7:0] CHAR_LC_R   = 8'h72;
  localparam logic [7:0] CHAR_LC_T   = 8'h74;
  localparam logic [7:0] CHAR_LC_U   = 8'h75;
  localparam logic [7:0] CHAR_LC_X   = 8'h78;
  localparam logic [7:0] CHAR_BS     = 8'h08;
  localparam logic [7:0] CHAR_FF     = 8'h0C;
  localparam logic [7:0] CHAR_LF     = 8'h0A;
  localparam logic [7:0] CHAR_CR     = 8'h0D;
  localparam logic [7:0] CHAR_TAB    = 8'h09;

  localparam logic [7:0]  QUOTE_RESET  = CHAR_DQUOTE;
  localparam logic [2:0]  DIGITS_X     = 3'd2;
  localparam logic [2:0]  DIGITS_U     = 3'd4;
  localparam logic [31:0] COUNT_MAX    = 32'hFFFF_FFFF;

  // decoder state carried between items
  typedef struct packed {
    mode_t       mode;
    logic [2:0]  digits_left;
    logic [15:0] hex_accum;
    logic [31:0] byte_count;
  } dec_state_t;

  // results caused by one item
  typedef struct packed {
    logic [1:0]      cnt;
    kind_t           kind;
    logic [2:0][7:0] bytes;
    logic [7:0]      bad;
    logic [31:0]     len;
  } res_bundle_t;

  // hex digit decode: bit 4 is the valid flag, bits 3:0 the value
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end
    return r;
  endfunction

endpackage

FILE: design/sue_ifs.sv
// valid/ready channel interfaces for the string unescaper
`timescale 1ns / 1ps

interface sue_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;

  modport source (output valid, output char_in, input ready);
  modport sink   (input valid, input char_in, output ready);
endinterface

interface sue_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  out_byte;
  logic [7:0]  bad_char;
  logic [31:0] total_len;
  logic        last;

  modport source (output valid, output kind, output out_byte, output bad_char,
                  output total_len, output last, input ready);
  modport sink   (input valid, input kind, input out_byte, input bad_char,
                  input total_len, input last, output ready);
endinterface

FILE: design/sue_decode.sv
// next-state and result logic for one source character
`timescale 1ns / 1ps

module sue_decode (
  input  sue_pkg::dec_state_t  st,
  input  logic [7:0]           char_in,
  input  logic [7:0]           quote_char,
  output sue_pkg::dec_state_t  st_nxt,
  output sue_pkg::res_bundle_t res
);
  import sue_pkg::*;

  logic        do_normal;
  logic        restart;
  logic [1:0]  add_n;
  logic [4:0]  hd;
  logic [15:0] acc;
  logic [2:0]  dl;
  logic [32:0] sum;

  assign hd = hex_digit(char_in);

  always_comb begin
    st_nxt    = st;
    res       = '0;
    res.kind  = KIND_BYTE;
    do_normal = 1'b0;
    restart   = 1'b0;
    add_n     = 2'd0;
    acc       = {st.hex_accum[11:0], hd[3:0]};
    dl        = (st.digits_left == 3'd0) ? 3'd0 : st.digits_left - 3'd1;

    case (st.mode)
      // character after a backslash
      MODE_ESC: begin
        st_nxt.mode = MODE_NORMAL;
        add_n = 2'd1;
        case (char_in)
          CHAR_DQUOTE: res.bytes[0] = CHAR_DQUOTE;
          CHAR_APOS:   res.bytes[0] = CHAR_APOS;
          CHAR_BSLASH: res.bytes[0] = CHAR_BSLASH;
          CHAR_SLASH:  res.bytes[0] = CHAR_SLASH;
          CHAR_LC_B:   res.bytes[0] = CHAR_BS;
          CHAR_LC_F:   res.bytes[0] = CHAR_FF;
          CHAR_LC_N:   res.bytes[0] = CHAR_LF;
          CHAR_LC_R:   res.bytes[0] = CHAR_CR;
          CHAR_LC_T:   res.bytes[0] = CHAR_TAB;
          CHAR_LC_X: begin
            add_n = 2'd0;
            st_nxt.mode = MODE_HEX_X;
            st_nxt.digits_left = DIGITS_X;
            st_nxt.hex_accum = '0;
          end
          CHAR_LC_U: begin
            add_n = 2'd0;
            st_nxt.mode = MODE_HEX_U;
            st_nxt.digits_left = DIGITS_U;
            st_nxt.hex_accum = '0;
          end
          default: begin
            add_n = 2'd0;
            do_normal = 1'b1;
          end
        endcase
      end
      // hex digits of \x or \u
      MODE_HEX_X, MODE_HEX_U: begin
        if (!hd[4]) begin
          res.cnt  = 2'd1;
          res.kind = KIND_ERR;
          res.bad  = char_in;
          restart  = 1'b1;
        end else if (dl != 3'd0) begin
          st_nxt.hex_accum   = acc;
          st_nxt.digits_left = dl;
        end else begin
          st_nxt.mode        = MODE_NORMAL;
          st_nxt.hex_accum   = '0;
          st_nxt.digits_left = 3'd0;
          if (st.mode == MODE_HEX_X || acc < 16'h0080) begin
            add_n = 2'd1;
            res.bytes[0] = acc[7:0];
          end else if (acc < 16'h0800) begin
            add_n = 2'd2;
            res.bytes[0] = {3'b110, acc[10:6]};
            res.bytes[1] = {2'b10, acc[5:0]};
          end else begin
            add_n = 2'd3;
            res.bytes[0] = {4'b1110, acc[15:12]};
            res.bytes[1] = {2'b10, acc[11:6]};
            res.bytes[2] = {2'b10, acc[5:0]};
          end
        end
      end
      default: begin
        st_nxt.mode = MODE_NORMAL;
        do_normal = 1'b1;
      end
    endcase

    // literal character handling, shared with unknown escapes
    if (do_normal) begin
      if (char_in == quote_char || char_in == CHAR_NUL) begin
        res.cnt  = 2'd1;
        res.kind = KIND_END;
        res.len  = st.byte_count;
        restart  = 1'b1;
      end else if (char_in == CHAR_BSLASH) begin
        st_nxt.mode = MODE_ESC;
      end else begin
        add_n = 2'd1;
        res.bytes[0] = char_in;
      end
    end

    // byte counter with saturation
    sum = {1'b0, st.byte_count} + {31'd0, add_n};
    if (add_n != 2'd0) begin
      res.cnt = add_n;
      st_nxt.byte_count = sum[32] ? COUNT_MAX : sum[31:0];
    end

    if (restart) begin
      st_nxt.mode        = MODE_NORMAL;
      st_nxt.digits_left = 3'd0;
      st_nxt.hex_accum   = '0;
      st_nxt.byte_count  = '0;
    end
  end

endmodule

FILE: design/sue_out_buf.sv
// result register that hands out up to three results of one item
`timescale 1ns / 1ps

module sue_out_buf (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  sue_pkg::res_bundle_t res,
  output logic                 in_ready,
  sue_out_if.source            out_ch
);
  import sue_pkg::*;

  logic [1:0]      cnt_r, cnt_nxt;
  kind_t           kind_r;
  logic [2:0][7:0] bytes_r;
  logic [7:0]      bad_r;
  logic [31:0]     len_r;
  logic            fire;

  assign fire     = out_ch.valid && out_ch.ready;
  assign in_ready = (cnt_r == 2'd0) || (cnt_r == 2'd1 && out_ch.ready);

  // remaining result count
  always_comb begin
    cnt_nxt = cnt_r;
    if (load) begin
      cnt_nxt = res.cnt;
    end else if (fire) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // payload: load a new bundle or shift to the next byte
  always_ff @(posedge clk) begin
    if (load) begin
      kind_r  <= res.kind;
      bytes_r <= res.bytes;
      bad_r   <= res.bad;
      len_r   <= res.len;
    end else if (fire) begin
      bytes_r <= {8'h00, bytes_r[2:1]};
    end
  end

  assign out_ch.valid     = (cnt_r != 2'd0);
  assign out_ch.kind      = kind_r;
  assign out_ch.out_byte  = bytes_r[0];
  assign out_ch.bad_char  = bad_r;
  assign out_ch.total_len = len_r;
  assign out_ch.last      = (cnt_r == 2'd1);

  // only decoded bytes come in groups
  a_multi_only_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r > 2'd1) |-> (kind_r == KIND_BYTE))
    else $error("end or error result pending with more than one result");

  // a new bundle never overwrites results still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> (cnt_r == 2'd0 || (cnt_r == 2'd1 && out_ch.ready)))
    else $error("bundle loaded over pending results");

  // the rest of a group follows without a gap
  a_group_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && cnt_r > 2'd1) |=> (out_ch.valid && !in_ready || out_ch.ready))
    else $error("multi-byte group broken");

endmodule

FILE: design/string_unescape_utf8.sv
// top level of the string literal unescaper with utf-8 output
`timescale 1ns / 1ps
// latency: the first result of an item is presented the cycle after it is accepted
// throughput: one item per cycle while out_ch is ready; a multi-result item holds input
// until its last result is taken, set by the single result register
// reset (synchronous, rst_n low): normal mode, counter and hex state cleared,
// quote character back to double quote, no result pending

module string_unescape_utf8 (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [7:0] cfg_data,
  sue_in_if.sink     in_ch,
  sue_out_if.source  out_ch
);
  import sue_pkg::*;

  dec_state_t  st_r, st_nxt;
  res_bundle_t res;
  logic [7:0]  quote_r;
  logic        accept;

  assign accept = in_ch.valid && in_ch.ready;

  // quote character register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quote_r <= QUOTE_RESET;
    end else if (cfg_we) begin
      quote_r <= cfg_data;
    end
  end

  // decoder state advances on each accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.mode        <= MODE_NORMAL;
      st_r.digits_left <= 3'd0;
      st_r.hex_accum   <= '0;
      st_r.byte_count  <= '0;
    end else if (accept) begin
      st_r <= st_nxt;
    end
  end

  sue_decode u_decode (
    .st         (st_r),
    .char_in    (in_ch.char_in),
    .quote_char (quote_r),
    .st_nxt     (st_nxt),
    .res        (res)
  );

  sue_out_buf u_out_buf (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (accept),
    .res      (res),
    .in_ready (in_ch.ready),
    .out_ch   (out_ch)
  );

endmodule
